// ===== hdl/ito_pkg.sv =====
package ito_pkg;

  localparam int VAL_W   = 64;
  localparam int DEC_W   = 32;
  localparam int MODE_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int CNT_W   = 5;
  localparam int DIG_W   = 4;
  localparam int MAX_DIG = 16;
  localparam int PTR_W   = $clog2(MAX_DIG);

  localparam logic [MODE_W-1:0] MODE_SDEC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UDEC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LHEX = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UHEX = 2'd3;

  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_UA    = 8'h41;

  // reciprocal of ten, scaled by 2^35
  localparam logic [DEC_W-1:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int RECIP_SH = 35;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } ito_state_t;

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIG_W-1:0] d,
                                                     input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? ASCII_UA : ASCII_LA;
    if (d < 4'd10) begin
      digit_ascii = ASCII_ZERO + {4'b0, d};
    end else begin
      digit_ascii = base + {4'b0, d - 4'd10};
    end
  endfunction

endpackage

// ===== hdl/integer_to_ascii_formatter_top.sv =====
// integer to ascii formatter
// in channel: in_value (64 bits) and in_mode (2 bits) form one beat; mode 0 is
//   signed decimal of bits 31..0, 1 unsigned decimal of bits 31..0, 2 lower hex
//   and 3 upper hex of all 64 bits
// out channel: one beat per character, most significant first, no leading
//   zeros; out_last marks the final character and out_char_count then gives
//   the character total (1..16), it is zero on every other beat
// a number with d digits passes through the shared divide unit (divide by
//   ten through a reciprocal multiply, or a nibble shift for hex), one digit a
//   cycle, then d characters (plus a minus sign if negative) leave at one per
//   cycle while out_ready stays high; in_ready is high only while the
//   sequencer is idle, so no new number is taken while the previous one is
//   still converting or emitting
// the first character reaches the output register once every digit is produced
// reset (synchronous, active low) returns the sequencer to idle and drops
//   out_valid; no clearing pass is needed
// a stall on out_ready holds the current character in the output register and
//   freezes emission; the final character may still wait there while the
//   next number is accepted
module integer_to_ascii_formatter_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ito_pkg::VAL_W-1:0]   in_value,
  input  logic [ito_pkg::MODE_W-1:0]  in_mode,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ito_pkg::CHAR_W-1:0]  out_character,
  output logic                        out_last,
  output logic [ito_pkg::CNT_W-1:0]   out_char_count
);
  import ito_pkg::*;

  ito_state_t state_r, state_nxt;

  // working operand of the shared divide unit
  logic [VAL_W-1:0] mag_r, mag_nxt;
  logic             hex_r, hex_nxt;
  logic             upper_r, upper_nxt;
  logic             neg_r, neg_nxt;
  logic             sign_pend_r, sign_pend_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;

  // digit buffer, least significant digit at index 0
  logic [DIG_W-1:0] dig_r [MAX_DIG];
  logic             dig_we;

  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic [VAL_W-1:0] div_quo;
  logic [DIG_W-1:0] div_rem;
  logic [DEC_W-1:0] low;
  logic             in_beat;
  logic             out_free;

  ito_divu u_divu (
    .mag (mag_r),
    .hex (hex_r),
    .quo (div_quo),
    .rem (div_rem)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign low      = in_value[DEC_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    hex_r       <= hex_nxt;
    upper_r     <= upper_nxt;
    neg_r       <= neg_nxt;
    sign_pend_r <= sign_pend_nxt;
    cnt_r       <= cnt_nxt;
    ptr_r       <= ptr_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_cnt_r   <= out_cnt_nxt;
    if (dig_we) begin
      dig_r[cnt_r[PTR_W-1:0]] <= div_rem;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    hex_nxt       = hex_r;
    upper_nxt     = upper_r;
    neg_nxt       = neg_r;
    sign_pend_nxt = sign_pend_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    dig_we        = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_cnt_nxt   = out_cnt_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          hex_nxt   = (in_mode == MODE_LHEX) || (in_mode == MODE_UHEX);
          upper_nxt = (in_mode == MODE_UHEX);
          cnt_nxt   = '0;
          if (in_mode == MODE_SDEC && low[DEC_W-1]) begin
            neg_nxt = 1'b1;
            mag_nxt = {{VAL_W-DEC_W{1'b0}}, ~low + 32'd1};
          end else if (in_mode == MODE_SDEC || in_mode == MODE_UDEC) begin
            neg_nxt = 1'b0;
            mag_nxt = {{VAL_W-DEC_W{1'b0}}, low};
          end else begin
            neg_nxt = 1'b0;
            mag_nxt = in_value;
          end
          sign_pend_nxt = neg_nxt;
          state_nxt     = ST_CONV;
        end
      end

      ST_CONV: begin
        // one digit per cycle out of the shared unit
        dig_we  = 1'b1;
        mag_nxt = div_quo;
        cnt_nxt = cnt_r + 5'd1;
        if (div_quo == '0 || cnt_r == CNT_W'(MAX_DIG - 1)) begin
          ptr_nxt   = cnt_r[PTR_W-1:0];
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (sign_pend_r) begin
            out_char_nxt  = ASCII_MINUS;
            out_last_nxt  = 1'b0;
            out_cnt_nxt   = '0;
            sign_pend_nxt = 1'b0;
          end else begin
            out_char_nxt = digit_ascii(dig_r[ptr_r], upper_r);
            if (ptr_r == '0) begin
              out_last_nxt = 1'b1;
              out_cnt_nxt  = cnt_r + {{CNT_W-1{1'b0}}, neg_r};
              state_nxt    = ST_IDLE;
            end else begin
              out_last_nxt = 1'b0;
              out_cnt_nxt  = '0;
              ptr_nxt      = ptr_r - 4'd1;
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_character  = out_char_r;
  assign out_last       = out_last_r;
  assign out_char_count = out_cnt_r;

  // count appears only on the final character
  a_cnt_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_char_count == '0)
    else $error("char count on a non-final character");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_char_count != '0 && out_char_count <= 5'd16)
    else $error("char count out of range");

  // an accepted number always moves on to conversion in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && state_r == ST_CONV)
    else $error("sequencer did not start conversion");

  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CONV |-> cnt_r < 5'd16)
    else $error("digit count overflow");

endmodule

// ===== hdl/ito_divu.sv =====
module ito_divu (
  input  logic [ito_pkg::VAL_W-1:0] mag,
  input  logic                      hex,
  output logic [ito_pkg::VAL_W-1:0] quo,
  output logic [ito_pkg::DIG_W-1:0] rem
);
  import ito_pkg::*;

  logic [DEC_W-1:0]   low;
  logic [2*DEC_W-1:0] prod;
  logic [DEC_W-1:0]   q10;
  logic [DEC_W-1:0]   dq;
  logic [DEC_W-1:0]   dr;

  // divide by ten via reciprocal multiply, exact over 32 bits
  assign low  = mag[DEC_W-1:0];
  assign prod = {{DEC_W{1'b0}}, low} * {{DEC_W{1'b0}}, RECIP10};
  assign dq   = {{RECIP_SH-DEC_W{1'b0}}, prod[2*DEC_W-1:RECIP_SH]};
  assign q10  = {dq[DEC_W-4:0], 3'b000} + {dq[DEC_W-2:0], 1'b0};
  assign dr   = low - q10;

  always_comb begin
    if (hex) begin
      quo = {4'b0000, mag[VAL_W-1:DIG_W]};
      rem = mag[DIG_W-1:0];
    end else begin
      quo = {{VAL_W-DEC_W{1'b0}}, dq};
      rem = dr[DIG_W-1:0];
    end
  end

endmodule

// ===== tb/sv/ascii_text_checker.sv =====
module ascii_text_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [ito_pkg::VAL_W-1:0]  in_value,
  input  logic [ito_pkg::MODE_W-1:0] in_mode,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [ito_pkg::CHAR_W-1:0] out_character,
  input  logic                       out_last,
  input  logic [ito_pkg::CNT_W-1:0]  out_char_count,
  output int                         fail_count,
  output int                         chars_pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import ito_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic [CNT_W-1:0]  count;
  } text_beat_t;

  text_beat_t expected_chars[$];

  // builds the text of one number and queues one beat per character
  function automatic void format_number(input logic [VAL_W-1:0] v,
                                        input logic [MODE_W-1:0] m);
    string             hex_lo;
    string             hex_up;
    logic [CHAR_W-1:0] digits [MAX_DIG];
    logic [VAL_W-1:0]  mag;
    logic              neg;
    int                nd;
    int                total;
    int                pos;
    text_beat_t        beat;
    hex_lo = "0123456789abcdef";
    hex_up = "0123456789ABCDEF";
    nd = 0;
    neg = 1'b0;
    if (m == MODE_SDEC || m == MODE_UDEC) begin
      mag = {32'b0, v[DEC_W-1:0]};
      if (m == MODE_SDEC && v[DEC_W-1]) begin
        neg = 1'b1;
        mag = {32'b0, DEC_W'(~v[DEC_W-1:0] + 1'b1)};
      end
      do begin
        digits[nd] = ASCII_ZERO + CHAR_W'(mag % 10);
        nd++;
        mag = mag / 10;
      end while (mag != 0);
    end else begin
      mag = v;
      do begin
        digits[nd] = (m == MODE_UHEX) ? hex_up[mag[3:0]] : hex_lo[mag[3:0]];
        nd++;
        mag = mag >> 4;
      end while (mag != 0);
    end
    total = nd + (neg ? 1 : 0);
    pos = 0;
    if (neg) begin
      beat.ch = ASCII_MINUS;
      beat.last = 1'b0;
      beat.count = '0;
      expected_chars.push_back(beat);
      pos++;
    end
    for (int k = nd - 1; k >= 0; k--) begin
      beat.ch = digits[k];
      beat.last = (pos == total - 1);
      beat.count = beat.last ? CNT_W'(total) : '0;
      expected_chars.push_back(beat);
      pos++;
    end
  endfunction

  initial begin
    fail_count = 0;
    chars_pending = 0;
  end

  always @(posedge clk) begin
    text_beat_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        format_number(in_value, in_mode);
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected beat: character %h last %b count %0d",
                 out_character, out_last, out_char_count);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_character !== want.ch) begin
            $error("out_character: expected %h, got %h", want.ch, out_character);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %b, got %b", want.last, out_last);
            fail_count++;
          end
          if (out_char_count !== want.count) begin
            $error("out_char_count: expected %0d, got %0d", want.count, out_char_count);
            fail_count++;
          end
        end
      end
      chars_pending <= expected_chars.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import ito_pkg::*;

  // generous bound for ~210 numbers plus stalls and the hold
  localparam int CYCLE_LIMIT    = 200000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int RANDOM_NUMBERS = 180;
  localparam int DRAIN_CYCLES   = 40;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [VAL_W-1:0]  in_value;
  logic [MODE_W-1:0] in_mode;
  logic              out_valid;
  logic              out_ready;
  logic [CHAR_W-1:0] out_character;
  logic              out_last;
  logic [CNT_W-1:0]  out_char_count;

  int fail_count;
  int chars_pending;
  int cycle_count;

  // random gaps on both channels, switched off for a long clean stretch
  bit gaps_on;
  // asks the receiver process for one long back-pressure stretch
  bit rx_hold_req;

  integer_to_ascii_formatter_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_mode        (in_mode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_character  (out_character),
    .out_last       (out_last),
    .out_char_count (out_char_count)
  );

  // watches both channels, predicts the text of every accepted number
  ascii_text_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_mode        (in_mode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_character  (out_character),
    .out_last       (out_last),
    .out_char_count (out_char_count),
    .fail_count     (fail_count),
    .chars_pending  (chars_pending)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // every input known from time zero
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    in_mode = MODE_SDEC;
    out_ready = 1'b0;
    gaps_on = 1'b1;
    rx_hold_req = 1'b0;
  end

  // watchdog: a hung handshake ends the run here
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: ready changes on the falling edge and goes low at random, with a
  // 6 percent chance, while gaps are on; on request one long hold-off counted here
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
        rx_hold_req = 1'b0;
      end else begin
        out_ready <= !(gaps_on && $urandom_range(99) < 6);
      end
    end
  end

  // offers one number; entered and left on a falling edge, valid stays high
  // until the beat is taken at a rising edge
  task automatic send_number(input logic [VAL_W-1:0] v, input logic [MODE_W-1:0] m);
    while (gaps_on && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_mode <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // sender goes quiet until every queued character has come out
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (chars_pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [VAL_W-1:0]  v;
    logic [MODE_W-1:0] m;

    // reset held low from time zero, released on a falling edge
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero in every mode
    send_number(64'd0, MODE_SDEC);
    send_number(64'd0, MODE_UDEC);
    send_number(64'd0, MODE_LHEX);
    send_number(64'd0, MODE_UHEX);
    // signed decimal: minus one, most negative, most positive, small ones
    send_number(64'h0000_0000_FFFF_FFFF, MODE_SDEC);
    send_number(64'h0000_0000_8000_0000, MODE_SDEC);
    send_number(64'h0000_0000_7FFF_FFFF, MODE_SDEC);
    send_number(64'h0000_0000_FFFF_FFF6, MODE_SDEC);
    send_number(64'd9, MODE_SDEC);
    // upper bits must be ignored in both decimal modes
    send_number(64'hDEAD_BEEF_8000_0000, MODE_SDEC);
    send_number(64'hFFFF_FFFF_0000_0000, MODE_UDEC);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_UDEC);
    send_number(64'd10, MODE_UDEC);
    send_number(64'd1_000_000_000, MODE_UDEC);
    // hex: full width, top bit only, every digit, single letter
    send_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_LHEX);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_UHEX);
    send_number(64'h8000_0000_0000_0000, MODE_LHEX);
    send_number(64'h0123_4567_89AB_CDEF, MODE_LHEX);
    send_number(64'h0123_4567_89AB_CDEF, MODE_UHEX);
    send_number(64'hFEDC_BA98_7654_3210, MODE_UHEX);
    send_number(64'hA, MODE_LHEX);
    send_number(64'hA, MODE_UHEX);

    // pause until the pipe is empty, then stall the receiver while numbers
    // keep coming so the block fills and holds off its input
    wait_for_drain();
    rx_hold_req = 1'b1;
    send_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_UHEX);
    send_number(64'h0000_0000_8000_0000, MODE_SDEC);
    send_number(64'h1234_5678_9ABC_DEF0, MODE_LHEX);
    send_number(64'h0000_0000_FFFF_FFFF, MODE_UDEC);
    wait_for_drain();

    // random part: lengths spread by shifting, plus powers of two and tiny values;
    // the middle third runs with no gaps at all
    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      gaps_on = !(i >= RANDOM_NUMBERS / 3 && i < 2 * RANDOM_NUMBERS / 3);
      m = MODE_W'($urandom_range(3));
      case ($urandom_range(3))
        0: v = {$urandom, $urandom};
        1: v = {$urandom, $urandom} >> $urandom_range(63);
        2: v = (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
        default: v = {$urandom, 32'($urandom_range(20))};
      endcase
      // in decimal modes a short magnitude can still come with junk above bit 31
      if (m == MODE_SDEC || m == MODE_UDEC) begin
        if ($urandom_range(1) == 1) begin
          v[DEC_W-1:0] = v[DEC_W-1:0] >> $urandom_range(31);
        end
      end
      send_number(v, m);
    end
    gaps_on = 1'b1;

    // end: drain, then keep watching for any stray beat before the verdict
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ito_pkg.sv
hdl/ito_divu.sv
hdl/integer_to_ascii_formatter_top.sv
tb/sv/ascii_text_checker.sv
tb/sv/testbench.sv
